FILE: rtl/dto_pkg.sv
// Shared types and constants for the topological sort block.
// Used by dto_ctrl, dto_datapath, dag_topological_order and the test files.
`timescale 1ns / 1ps

package dto_pkg;

  localparam int ID_W          = 6;    // task id width
  localparam int ID_SPACE      = 64;   // ids that the id field can name
  localparam int FIFO_AW       = 6;    // address width of the ready queue
  localparam int CNT_W         = 7;    // counts of tasks, 0 to ID_SPACE
  localparam int CFG_W         = 7;    // width of tasks_in_use
  localparam int S_DATA_W      = 16;   // src_task, dst_task, padded
  localparam int M_DATA_W      = 8;    // task_id, incomplete, edge_overflow
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 3;
  localparam int MAX_TASKS_DEF = 64;
  localparam int MAX_EDGES_DEF = 256;

  localparam logic [CFG_W-1:0] TASKS_RESET = 7'd64;

  // register index, taken from paddr[2]
  localparam logic REG_TASKS_IN_USE = 1'b0;

  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_RUN  = 1'b1
  } kind_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic edge_load;
    logic run_start;
    logic load_inc;
    logic seed_rd;
    logic seed_chk;
    logic pop_rd;
    logic pop_take;
    logic edge_rd;
    logic edge_chk;
    logic deg_upd;
    logic finish;
  } dto_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic seed_done;
    logic fifo_empty;
    logic scan_done;
    logic edge_hit;
    logic out_busy;
    logic have_held;
  } dto_stat_t;

endpackage

FILE: rtl/dto_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read word while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/dto_ctrl.sv
// Sequencer for edge loads and sort runs: seed, pop, edge scan, finish.
// Depends on dto_pkg for the command and status structs.
`timescale 1ns / 1ps

module dto_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              s_tuser,     // kind
  input  dto_pkg::dto_stat_t stat,
  output dto_pkg::dto_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_INC,
    ST_SEED_RD,
    ST_SEED_CHK,
    ST_POP_RD,
    ST_POP_GOT,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_DEG_UPD,
    ST_FINISH
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (dto_pkg::kind_t'(s_tuser) == dto_pkg::KIND_RUN) begin
            cmd.run_start = 1'b1;
            state_next    = ST_SEED_RD;
          end else begin
            cmd.edge_load = 1'b1;
            state_next    = ST_LOAD_INC;
          end
        end
      end
      ST_LOAD_INC: begin
        cmd.load_inc = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_SEED_RD: begin
        if (stat.seed_done) begin
          state_next = ST_POP_RD;
        end else begin
          cmd.seed_rd = 1'b1;
          state_next  = ST_SEED_CHK;
        end
      end
      ST_SEED_CHK: begin
        cmd.seed_chk = 1'b1;
        state_next   = ST_SEED_RD;
      end
      ST_POP_RD: begin
        if (stat.fifo_empty) begin
          state_next = ST_FINISH;
        end else begin
          cmd.pop_rd = 1'b1;
          state_next = ST_POP_GOT;
        end
      end
      ST_POP_GOT: begin
        // hold while the previous task cannot be sent on
        if (!(stat.have_held && stat.out_busy)) begin
          cmd.pop_take = 1'b1;
          state_next   = ST_EDGE_RD;
        end
      end
      ST_EDGE_RD: begin
        if (stat.scan_done) begin
          state_next = ST_POP_RD;
        end else begin
          cmd.edge_rd = 1'b1;
          state_next  = ST_EDGE_CHK;
        end
      end
      ST_EDGE_CHK: begin
        if (stat.edge_hit) begin
          cmd.edge_chk = 1'b1;
          state_next   = ST_DEG_UPD;
        end else begin
          state_next = ST_EDGE_RD;
        end
      end
      ST_DEG_UPD: begin
        cmd.deg_upd = 1'b1;
        state_next  = ST_EDGE_RD;
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/dto_datapath.sv
// Edge store, in-degree store, ready queue, counters, config register and
// output register. Depends on dto_pkg and dto_ram.
`timescale 1ns / 1ps

module dto_datapath #(
  parameter int MAX_TASKS = dto_pkg::MAX_TASKS_DEF,
  parameter int MAX_EDGES = dto_pkg::MAX_EDGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dto_pkg::dto_cmd_t               cmd,
  output dto_pkg::dto_stat_t              stat,
  input  logic [dto_pkg::S_DATA_W-1:0]    s_tdata,   // src_task, dst_task
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dto_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dto_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dto_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dto_pkg::M_DATA_W-1:0]    m_tdata,   // task_id, incomplete, edge_overflow
  output logic                            m_tuser,   // task_valid
  output logic                            m_tlast
);

  localparam int ID_W       = dto_pkg::ID_W;
  localparam int CNT_W      = dto_pkg::CNT_W;
  localparam int IDEG_DEPTH = (MAX_TASKS < dto_pkg::ID_SPACE) ? MAX_TASKS : dto_pkg::ID_SPACE;
  localparam int IDEG_AW    = $clog2(IDEG_DEPTH);
  localparam int ECNT_W     = $clog2(MAX_EDGES + 1);
  localparam int EADDR_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int DEG_W      = ECNT_W;

  localparam logic [CNT_W-1:0]  IDEG_LIMIT = CNT_W'(IDEG_DEPTH);
  localparam logic [ECNT_W-1:0] EDGE_LIMIT = ECNT_W'(MAX_EDGES);
  localparam logic [CNT_W-1:0]  FIFO_LIMIT = CNT_W'(dto_pkg::ID_SPACE);

  logic [ID_W-1:0] in_src, in_dst;
  assign in_src = s_tdata[ID_W-1:0];
  assign in_dst = s_tdata[2*ID_W-1:ID_W];

  // config and run state
  logic [dto_pkg::CFG_W-1:0] tasks_in_use;
  logic [CNT_W-1:0]          n_act;
  logic [ECNT_W-1:0]         edge_count;
  logic                      overflow_seen;
  logic [IDEG_DEPTH-1:0]     deg_valid;
  logic [IDEG_AW-1:0]        load_dst;
  logic                      inc_pend;
  logic [CNT_W-1:0]          seed_idx;
  logic [CNT_W-1:0]          head, tail;
  logic [CNT_W-1:0]          emitted;
  logic [ECNT_W-1:0]         edge_idx;
  logic [ID_W-1:0]           held;
  logic                      have_held;
  logic [IDEG_AW-1:0]        upd_dst;

  // output register
  logic [ID_W-1:0] out_task;
  logic            out_tvld, out_last, out_inc, out_ovf;

  assign n_act = (CNT_W'(tasks_in_use) < IDEG_LIMIT) ? CNT_W'(tasks_in_use) : IDEG_LIMIT;

  // edge store
  logic                 load_ok;
  logic [2*ID_W-1:0]    edge_q;
  logic [ID_W-1:0]      e_src, e_dst;

  assign load_ok = (edge_count < EDGE_LIMIT);
  assign e_src   = edge_q[ID_W-1:0];
  assign e_dst   = edge_q[2*ID_W-1:ID_W];

  dto_ram #(.WIDTH(2*ID_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (cmd.edge_load && load_ok),
    .waddr (edge_count[EADDR_W-1:0]),
    .wdata ({in_dst, in_src}),
    .re    (cmd.edge_rd),
    .raddr (edge_idx[EADDR_W-1:0]),
    .rdata (edge_q)
  );

  // in-degree store; an entry without its valid bit reads as zero
  logic               deg_re, deg_we;
  logic [IDEG_AW-1:0] deg_raddr, deg_waddr, chk_addr;
  logic [DEG_W-1:0]   deg_q, deg_cur, deg_wdata;

  always_comb begin
    if (cmd.edge_load) begin
      deg_raddr = in_dst[IDEG_AW-1:0];
    end else if (cmd.seed_rd) begin
      deg_raddr = seed_idx[IDEG_AW-1:0];
    end else begin
      deg_raddr = e_dst[IDEG_AW-1:0];
    end
    if (cmd.load_inc) begin
      chk_addr = load_dst;
    end else if (cmd.seed_chk) begin
      chk_addr = seed_idx[IDEG_AW-1:0];
    end else begin
      chk_addr = upd_dst;
    end
  end

  assign deg_re    = cmd.edge_load || cmd.seed_rd || cmd.edge_chk;
  assign deg_cur   = deg_valid[chk_addr] ? deg_q : '0;
  assign deg_we    = (cmd.load_inc && inc_pend) || (cmd.deg_upd && (deg_cur != '0));
  assign deg_waddr = cmd.load_inc ? load_dst : upd_dst;
  assign deg_wdata = cmd.load_inc ? deg_cur + DEG_W'(1) : deg_cur - DEG_W'(1);

  dto_ram #(.WIDTH(DEG_W), .DEPTH(IDEG_DEPTH)) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .re    (deg_re),
    .raddr (deg_raddr),
    .rdata (deg_q)
  );

  // ready queue
  logic            seed_push, upd_push, push;
  logic [ID_W-1:0] push_id, fifo_q;

  assign seed_push = cmd.seed_chk && (deg_cur == '0);
  assign upd_push  = cmd.deg_upd && (deg_cur == DEG_W'(1)) && (CNT_W'(upd_dst) < n_act);
  assign push      = seed_push || upd_push;
  assign push_id   = cmd.seed_chk ? seed_idx[ID_W-1:0] : ID_W'(upd_dst);

  dto_ram #(.WIDTH(ID_W), .DEPTH(dto_pkg::ID_SPACE)) u_fifo_ram (
    .clk   (clk),
    .we    (push),
    .waddr (tail[dto_pkg::FIFO_AW-1:0]),
    .wdata (push_id),
    .re    (cmd.pop_rd),
    .raddr (head[dto_pkg::FIFO_AW-1:0]),
    .rdata (fifo_q)
  );

  // status
  logic out_busy, load_out, cfg_wr;

  assign out_busy = m_tvalid && !m_tready;
  assign load_out = (cmd.pop_take && have_held) || cmd.finish;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == dto_pkg::REG_TASKS_IN_USE);

  always_comb begin
    stat.seed_done  = (seed_idx >= n_act);
    stat.fifo_empty = (head == tail);
    stat.scan_done  = (edge_idx == edge_count);
    stat.edge_hit   = (e_src == held) && (CNT_W'(e_dst) < IDEG_LIMIT);
    stat.out_busy   = out_busy;
    stat.have_held  = have_held;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tasks_in_use  <= dto_pkg::TASKS_RESET;
      edge_count    <= '0;
      overflow_seen <= 1'b0;
      deg_valid     <= '0;
      have_held     <= 1'b0;
      m_tvalid      <= 1'b0;
      seed_idx      <= '0;
      head          <= '0;
      tail          <= '0;
      emitted       <= '0;
      edge_idx      <= '0;
      inc_pend      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        tasks_in_use <= pwdata[dto_pkg::CFG_W-1:0];
      end
      if (cmd.edge_load) begin
        if (load_ok) begin
          edge_count <= edge_count + ECNT_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
        inc_pend <= load_ok && (CNT_W'(in_dst) < IDEG_LIMIT);
      end
      if (deg_we) begin
        deg_valid[deg_waddr] <= 1'b1;
      end
      if (cmd.run_start) begin
        seed_idx  <= '0;
        head      <= '0;
        tail      <= '0;
        emitted   <= '0;
        have_held <= 1'b0;
      end
      if (cmd.seed_chk) begin
        seed_idx <= seed_idx + CNT_W'(1);
      end
      if (push) begin
        tail <= tail + CNT_W'(1);
      end
      if (cmd.pop_rd) begin
        head <= head + CNT_W'(1);
      end
      if (cmd.pop_take) begin
        have_held <= 1'b1;
        emitted   <= emitted + CNT_W'(1);
        edge_idx  <= '0;
      end
      if (cmd.edge_rd) begin
        edge_idx <= edge_idx + ECNT_W'(1);
      end
      // drop the edge store, in-degrees, overflow flag and held task once the run ends
      if (cmd.finish) begin
        edge_count    <= '0;
        overflow_seen <= 1'b0;
        deg_valid     <= '0;
        have_held     <= 1'b0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.edge_load) begin
      load_dst <= in_dst[IDEG_AW-1:0];
    end
    if (cmd.pop_take) begin
      held <= fifo_q;
    end
    if (cmd.edge_chk) begin
      upd_dst <= e_dst[IDEG_AW-1:0];
    end
    if (load_out) begin
      // with no task emitted the last item is a bare marker
      out_task <= (cmd.finish && !have_held) ? '0 : held;
      out_tvld <= cmd.finish ? have_held : 1'b1;
      out_last <= cmd.finish;
      out_inc  <= cmd.finish && (emitted < n_act);
      out_ovf  <= cmd.finish && overflow_seen;
    end
  end

  assign m_tdata = {out_ovf, out_inc, out_task};
  assign m_tuser = out_tvld;
  assign m_tlast = out_last;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == dto_pkg::REG_TASKS_IN_USE)
                  ? dto_pkg::APB_DATA_W'(tasks_in_use) : '0;

  a_queue_order: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("ready queue read pointer passed write pointer");
  a_queue_bound: assert property (@(posedge clk) disable iff (rst) tail <= FIFO_LIMIT)
    else $error("ready queue overfilled");
  a_edge_bound: assert property (@(posedge clk) disable iff (rst) edge_count <= EDGE_LIMIT)
    else $error("edge count beyond store depth");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst) !(load_out && out_busy))
    else $error("output item overwritten while stalled");

endmodule

FILE: rtl/dag_topological_order.sv
// Top level of the task-graph topological sort (Kahn's method).
// Depends on dto_pkg, dto_ctrl, dto_datapath (and through it dto_ram).
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tdata: src_task[5:0] dst_task[11:6]; tuser: kind
//  m_*       out        m_tvalid/m_tready  tdata: task_id[5:0] incomplete[6] edge_overflow[7];
//                                          tuser: task_valid; tlast: last
//  APB       in         psel/penable       register 0 at address 0: tasks_in_use[6:0]
//
// An edge item is handled as a store write with the in-degree read, then the in-degree increment.
// A run item seeds the ready queue from the n tasks in use, then for each emitted task
// walks every stored edge through the single edge-store read port and updates the
// in-degree of each successor found.
// rst is synchronous and active high; it empties the edge store and queue.
// A stalled output holds the sequencer before it sends the next item.
`timescale 1ns / 1ps

module dag_topological_order #(
  parameter int MAX_TASKS = dto_pkg::MAX_TASKS_DEF,
  parameter int MAX_EDGES = dto_pkg::MAX_EDGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [dto_pkg::S_DATA_W-1:0]    s_tdata,   // src_task, dst_task
  input  logic                            s_tuser,   // kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dto_pkg::M_DATA_W-1:0]    m_tdata,   // task_id, incomplete, edge_overflow
  output logic                            m_tuser,   // task_valid
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dto_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dto_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dto_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  dto_pkg::dto_cmd_t  cmd;
  dto_pkg::dto_stat_t stat;

  dto_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  dto_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .MAX_EDGES (MAX_EDGES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: test/dag_topological_order_checker.sv
// Checker for dag_topological_order: watches the item, result and register ports,
// predicts each run's task order and compares it field by field. Needs dto_pkg.
`timescale 1ns / 1ps

module dag_topological_order_checker #(
  parameter int MAX_TASKS = dto_pkg::MAX_TASKS_DEF,
  parameter int MAX_EDGES = dto_pkg::MAX_EDGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [dto_pkg::S_DATA_W-1:0]    s_tdata,   // src_task, dst_task
  input  logic                            s_tuser,   // kind
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [dto_pkg::M_DATA_W-1:0]    m_tdata,   // task_id, incomplete, edge_overflow
  input  logic                            m_tuser,   // task_valid
  input  logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dto_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dto_pkg::APB_DATA_W-1:0]  pwdata,
  input  logic                            pready,
  output int                              fail_count,
  output int                              orders_waiting
);

  localparam int ID_W     = dto_pkg::ID_W;
  localparam int CFG_W    = dto_pkg::CFG_W;
  localparam int ID_SPACE = dto_pkg::ID_SPACE;

  typedef struct packed {
    logic [ID_W-1:0] task_id;
    logic            task_valid;
    logic            last;
    logic            incomplete;
    logic            edge_overflow;
  } order_beat_t;

  logic [ID_W-1:0]  edge_src [MAX_EDGES];
  logic [ID_W-1:0]  edge_dst [MAX_EDGES];
  logic [8:0]       in_deg [MAX_TASKS];
  int               edge_total;
  logic             overflow_seen;
  logic [CFG_W-1:0] tasks_cfg;
  order_beat_t      expected_order[$];
  order_beat_t      head_beat;
  int               mismatches = 0;

  task automatic store_edge(input logic [ID_W-1:0] src, input logic [ID_W-1:0] dst);
    if (edge_total < MAX_EDGES) begin
      edge_src[edge_total] = src;
      edge_dst[edge_total] = dst;
      edge_total++;
      if (int'(dst) < MAX_TASKS) in_deg[dst]++;
    end else begin
      overflow_seen = 1'b1;
    end
  endtask

  // Kahn's walk over the stored edges; queue the whole run's results, then clear.
  task automatic predict_sort();
    int              n;
    int              head;
    int              real_count;
    logic [ID_W-1:0] ready[$];
    logic [ID_W-1:0] cur;
    logic [ID_W-1:0] d;
    order_beat_t     beat;
    order_beat_t     run_q[$];
    n = int'(tasks_cfg);
    if (n > MAX_TASKS) n = MAX_TASKS;
    if (n > ID_SPACE) n = ID_SPACE;
    for (int t = 0; t < n; t++) begin
      if (in_deg[t] == 0 && ready.size() < ID_SPACE) ready = {ready, ID_W'(t)};
    end
    head = 0;
    while (head < ready.size() && run_q.size() < ID_SPACE) begin
      cur = ready[head];
      head++;
      beat = '0;
      beat.task_id    = cur;
      beat.task_valid = 1'b1;
      run_q = {run_q, beat};
      for (int e = 0; e < edge_total; e++) begin
        d = edge_dst[e];
        if (edge_src[e] == cur && int'(d) < MAX_TASKS && in_deg[d] != 0) begin
          in_deg[d]--;
          if (in_deg[d] == 0 && int'(d) < n && ready.size() < ID_SPACE) ready = {ready, d};
        end
      end
    end
    real_count = run_q.size();
    // nothing emitted: one marker result carries the flags
    if (real_count == 0) run_q = {run_q, order_beat_t'('0)};
    beat = run_q.pop_back();
    beat.last          = 1'b1;
    beat.incomplete    = (real_count < n);
    beat.edge_overflow = overflow_seen;
    run_q = {run_q, beat};
    expected_order = {expected_order, run_q};
    edge_total    = 0;
    overflow_seen = 1'b0;
    foreach (in_deg[i]) in_deg[i] = '0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      edge_total    = 0;
      overflow_seen = 1'b0;
      tasks_cfg     = dto_pkg::TASKS_RESET;
      foreach (in_deg[i]) in_deg[i] = '0;
      expected_order.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == dto_pkg::REG_TASKS_IN_USE)
        tasks_cfg = pwdata[CFG_W-1:0];
      if (s_tvalid && s_tready) begin
        if (dto_pkg::kind_t'(s_tuser) == dto_pkg::KIND_RUN) predict_sort();
        else store_edge(s_tdata[ID_W-1:0], s_tdata[2*ID_W-1:ID_W]);
      end
      if (m_tvalid && m_tready) begin
        if (expected_order.size() == 0) begin
          $error("unexpected result: task_id %0d task_valid %0d last %0d",
                 m_tdata[ID_W-1:0], m_tuser, m_tlast);
          mismatches++;
        end else begin
          head_beat = expected_order.pop_front();
          check_field("task_id", head_beat.task_id, m_tdata[ID_W-1:0]);
          check_field("task_valid", head_beat.task_valid, m_tuser);
          check_field("last", head_beat.last, m_tlast);
          check_field("incomplete", head_beat.incomplete, m_tdata[ID_W]);
          check_field("edge_overflow", head_beat.edge_overflow, m_tdata[ID_W+1]);
        end
      end
    end
    orders_waiting <= expected_order.size();
    fail_count     <= mismatches;
  end

endmodule

FILE: test/dag_topological_order_tb.sv
// Top of the dag_topological_order testbench: clock, reset, edge and run items,
// task-count writes and the verdict. Needs dto_pkg and dag_topological_order_checker.
`timescale 1ns / 1ps

module dag_topological_order_tb;

  localparam int ID_W       = dto_pkg::ID_W;
  localparam int S_DATA_W   = dto_pkg::S_DATA_W;
  localparam int APB_DATA_W = dto_pkg::APB_DATA_W;

  localparam int STIM_ITEMS     = 480;
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 150000;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [S_DATA_W-1:0]            s_tdata;   // src_task, dst_task
  logic                           s_tuser;   // kind
  logic                           m_tvalid;
  logic                           m_tready;
  logic [dto_pkg::M_DATA_W-1:0]   m_tdata;   // task_id, incomplete, edge_overflow
  logic                           m_tuser;   // task_valid
  logic                           m_tlast;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [dto_pkg::APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0]          pwdata;
  logic [APB_DATA_W-1:0]          prdata;
  logic                           pready;

  int   fail_count;
  int   orders_waiting;
  int   items_sent = 0;
  int   quiet_cycles = 0;
  logic steady = 1'b0;

  dag_topological_order i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  dag_topological_order_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .fail_count     (fail_count),
    .orders_waiting (orders_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("dag_topological_order test failed");
      $finish;
    end
  end

  task automatic send_item(input dto_pkg::kind_t kind, input logic [ID_W-1:0] src,
                           input logic [ID_W-1:0] dst);
    if (!steady) begin
      while ($urandom_range(99) < 8) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(S_DATA_W-2*ID_W){1'b0}}, dst, src};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_run();
    send_item(dto_pkg::KIND_RUN, ID_W'($urandom), ID_W'($urandom));
  endtask

  // hold the sender until every predicted result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    // let the count from the last accepted item settle first
    @(posedge clk);
    while (orders_waiting != 0) @(posedge clk);
  endtask

  task automatic set_task_count(input int count);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {dto_pkg::REG_TASKS_IN_USE, 2'b00};
    pwdata  <= APB_DATA_W'(count);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly forward edges inside the tasks in use, some back edges, some noise
  task automatic send_graph_edge(input int n);
    int a;
    int b;
    int pick;
    pick = $urandom_range(99);
    if (n >= 2 && pick < 80) begin
      a = $urandom_range(n - 2, 0);
      b = $urandom_range(n - 1, a + 1);
    end else if (n >= 2 && pick < 88) begin
      a = $urandom_range(n - 1, 1);
      b = $urandom_range(a, 0);
    end else begin
      a = $urandom_range(63, 0);
      b = $urandom_range(63, 0);
    end
    send_item(dto_pkg::KIND_EDGE, ID_W'(a), ID_W'(b));
  endtask

  initial begin
    int phase;
    int n;
    int n_eff;
    int edges;
    int groups;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= dto_pkg::KIND_EDGE;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no edges with the reset count: every task in id order
    send_run();
    // no task in use: a lone marker, not incomplete
    set_task_count(0);
    send_run();
    // four tasks in a dependency loop: marker flagged incomplete
    set_task_count(4);
    send_item(dto_pkg::KIND_EDGE, 6'd3, 6'd0);
    send_item(dto_pkg::KIND_EDGE, 6'd0, 6'd1);
    send_item(dto_pkg::KIND_EDGE, 6'd1, 6'd2);
    send_item(dto_pkg::KIND_EDGE, 6'd2, 6'd3);
    send_run();
    // source not in use, destination not in use, duplicate edge
    send_item(dto_pkg::KIND_EDGE, 6'd0, 6'd63);
    send_item(dto_pkg::KIND_EDGE, 6'd63, 6'd1);
    send_item(dto_pkg::KIND_EDGE, 6'd0, 6'd2);
    send_item(dto_pkg::KIND_EDGE, 6'd2, 6'd3);
    send_item(dto_pkg::KIND_EDGE, 6'd1, 6'd3);
    send_item(dto_pkg::KIND_EDGE, 6'd0, 6'd2);
    send_run();
    // count above the id space is capped
    set_task_count(127);
    send_item(dto_pkg::KIND_EDGE, 6'd63, 6'd0);
    send_item(dto_pkg::KIND_EDGE, 6'd0, 6'd62);
    send_item(dto_pkg::KIND_EDGE, 6'd62, 6'd63);
    send_item(dto_pkg::KIND_EDGE, 6'd21, 6'd42);
    send_run();
    // self loop on the only task
    set_task_count(1);
    send_item(dto_pkg::KIND_EDGE, 6'd0, 6'd0);
    send_run();

    phase = 0;
    while (items_sent < STIM_ITEMS) begin
      case (phase)
        0:       n = 64;
        1:       n = 127;
        2:       n = 0;
        3:       n = 1;
        4:       n = 2;
        default: n = ($urandom_range(99) < 15) ? 64 : $urandom_range(24, 2);
      endcase
      n_eff  = (n > 64) ? 64 : n;
      steady = (phase == 4);
      set_task_count(n);
      groups = (phase == 5) ? 1 : $urandom_range(4, 1);
      repeat (groups) begin
        // one group overfills the edge store
        edges = (phase == 5) ? $urandom_range(264, 257) : $urandom_range(18, 0);
        repeat (edges) send_graph_edge(n_eff);
        send_run();
        if ($urandom_range(3) == 0) drain_results();
      end
      phase++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("dag_topological_order test passed");
    end else begin
      $display("dag_topological_order test failed");
    end
    $finish;
  end

endmodule
